// ===== hw/rtl/gfge_pkg.sv =====
// Package for the GF(2) Gauss-Jordan elimination block.
// Holds field widths, register indexes, action codes and reset defaults.
// No dependencies.
package gfge_pkg;

    // Default sizes of the matrix
    localparam int DEF_MAX_ROWS = 64;
    localparam int DEF_MAX_COLS = 64;

    // Field widths
    localparam int COEFF_W  = 64;
    localparam int ROWIDX_W = 6;
    localparam int PIVCOL_W = 6;
    localparam int RANK_W   = 7;
    localparam int CFG_W    = 7;
    localparam int CFG_IDX_W = 1;
    localparam int S_TDATA_W = 72;
    localparam int M_TDATA_W = 88;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS_IN_USE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS_IN_USE = 1'b1;

    // Configuration reset values
    localparam logic [CFG_W-1:0] CFG_ROWS_RESET = 7'd64;
    localparam logic [CFG_W-1:0] CFG_COLS_RESET = 7'd64;

    // Input item actions
    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_ELIM = 1'b1;

endpackage

// ===== hw/rtl/gfge_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Used for the row store and the pivot store. No dependencies.
module gfge_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write one entry, read one entry a cycle
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/gf2_gauss_jordan_eliminate_top.sv =====
// GF(2) Gauss-Jordan elimination block, top level.
// Uses gfge_pkg and two gfge_ram instances (row store and pivot store).

// A load item (tuser 0) writes one row of coefficients and parity.
// An eliminate item (tuser 1) reduces the first rows_in_use rows over the first
// cols_in_use columns to reduced row echelon form, then streams out one item per
// row, tlast on the final one. All work runs through the single read and write
// port of the row store, one row access per step: a pivot search reads and tests
// each row from the pivot place down, a swap exchanges the found row with the
// pivot-place row, and clearing a column reads each other row, rewrites it where
// its bit is set and records the pivot. Emitting reads each row and waits while
// the output register is full. The input is not ready from the start of an
// elimination until its last row sits in the output register; load items and
// new eliminations are taken while that last row waits to be taken.
module gf2_gauss_jordan_eliminate_top #(
    parameter int MAX_ROWS = gfge_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS = gfge_pkg::DEF_MAX_COLS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration write port
    input  logic                            i_cfg_we,
    input  logic [gfge_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [gfge_pkg::CFG_W-1:0]      i_cfg_wdata,
    // input stream
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    // tdata: row_index[5:0], row_coeffs[69:6], row_parity[70], zero[71]
    input  logic [gfge_pkg::S_TDATA_W-1:0]  i_s_tdata,
    // tuser: action
    input  logic                            i_s_tuser,
    // output stream
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    // tdata: out_coeffs[63:0], out_parity[64], out_row[70:65], has_pivot[71],
    //        pivot_column[77:72], matrix_rank[84:78], zero[87:85]
    output logic [gfge_pkg::M_TDATA_W-1:0]  o_m_tdata,
    output logic                            o_m_tlast
);

    localparam int AW = $clog2(MAX_ROWS);
    localparam int CW = $clog2(MAX_ROWS + 1);
    localparam int LW = $clog2(MAX_COLS + 1);
    localparam int DW = gfge_pkg::COEFF_W + 1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_COL,
        S_SR_RD,
        S_SR_EV,
        S_SW_RD,
        S_SW_EV,
        S_SW_WR,
        S_EL_RD,
        S_EL_EV,
        S_EM_RD,
        S_EM_WT
    } t_state;

    t_state r_state, n_state;

    logic [gfge_pkg::CFG_W-1:0]  r_cfg_rows, r_cfg_cols;
    logic [CW-1:0]               r_nrows, n_nrows;
    logic [LW-1:0]               r_ncols, n_ncols;
    logic [CW-1:0]               r_row, n_row;
    logic [CW-1:0]               r_piv, n_piv;
    logic [LW-1:0]               r_col, n_col;
    logic [AW-1:0]               r_found, n_found;
    logic [DW-1:0]               r_prow, n_prow;
    logic [gfge_pkg::RANK_W-1:0] r_rank, n_rank;
    logic                        r_m_tvalid, n_m_tvalid;
    logic [gfge_pkg::M_TDATA_W-1:0] r_m_tdata, n_m_tdata;
    logic                        r_m_tlast, n_m_tlast;

    // RAM ports
    logic                         w_we;
    logic [AW-1:0]                w_waddr;
    logic [DW-1:0]                w_wdata;
    logic [AW-1:0]                w_raddr;
    logic [DW-1:0]                w_rdata;
    logic                         w_pwe;
    logic [AW-1:0]                w_pwaddr;
    logic [gfge_pkg::PIVCOL_W-1:0] w_pwdata;
    logic [gfge_pkg::PIVCOL_W-1:0] w_prdata;

    // Input field views
    logic [gfge_pkg::ROWIDX_W-1:0] w_in_idx;
    logic [gfge_pkg::COEFF_W-1:0]  w_in_coeffs;
    logic                          w_in_parity;
    logic                          w_s_acc;
    logic [gfge_pkg::COEFF_W-1:0]  w_rd_coeffs;
    logic                          w_rd_bit;
    logic                          w_hp;
    logic                          w_out_free;
    logic                          w_row_last;

    assign w_in_idx    = i_s_tdata[5:0];
    assign w_in_coeffs = i_s_tdata[69:6];
    assign w_in_parity = i_s_tdata[70];
    assign o_s_tready  = (r_state == S_IDLE);
    assign w_s_acc     = i_s_tvalid && o_s_tready;
    assign w_rd_coeffs = w_rdata[gfge_pkg::COEFF_W-1:0];
    assign w_rd_bit    = w_rd_coeffs[gfge_pkg::PIVCOL_W'(r_col)];
    assign w_hp        = gfge_pkg::RANK_W'(r_row) < r_rank;
    assign w_out_free  = !r_m_tvalid || i_m_tready;
    assign w_row_last  = (r_row + CW'(1)) == r_nrows;

    // Row store: coefficients with parity on top
    gfge_ram #(
        .WIDTH(DW),
        .DEPTH(MAX_ROWS)
    ) u_row_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // Pivot store: pivot column of each pivot row
    gfge_ram #(
        .WIDTH(gfge_pkg::PIVCOL_W),
        .DEPTH(MAX_ROWS)
    ) u_piv_ram (
        .i_clk   (i_clk),
        .i_we    (w_pwe),
        .i_waddr (w_pwaddr),
        .i_wdata (w_pwdata),
        .i_raddr (w_raddr),
        .o_rdata (w_prdata)
    );

    // Sequencer: next state, RAM controls, output register
    always_comb begin
        n_state    = r_state;
        n_nrows    = r_nrows;
        n_ncols    = r_ncols;
        n_row      = r_row;
        n_piv      = r_piv;
        n_col      = r_col;
        n_found    = r_found;
        n_prow     = r_prow;
        n_rank     = r_rank;
        n_m_tvalid = r_m_tvalid;
        n_m_tdata  = r_m_tdata;
        n_m_tlast  = r_m_tlast;
        w_we       = 1'b0;
        w_waddr    = r_row[AW-1:0];
        w_wdata    = r_prow;
        w_raddr    = r_row[AW-1:0];
        w_pwe      = 1'b0;
        w_pwaddr   = r_piv[AW-1:0];
        w_pwdata   = gfge_pkg::PIVCOL_W'(r_col);

        // drop a taken output item
        if (r_m_tvalid && i_m_tready) begin
            n_m_tvalid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (w_s_acc) begin
                    if (i_s_tuser == gfge_pkg::ACT_LOAD) begin
                        w_we    = ({1'b0, w_in_idx} < 7'(MAX_ROWS));
                        w_waddr = AW'(w_in_idx);
                        w_wdata = {w_in_parity, w_in_coeffs};
                    end else begin
                        if (r_cfg_rows == '0) begin
                            n_nrows = CW'(1);
                        end else if (r_cfg_rows > 7'(MAX_ROWS)) begin
                            n_nrows = CW'(MAX_ROWS);
                        end else begin
                            n_nrows = CW'(r_cfg_rows);
                        end
                        n_ncols = (r_cfg_cols > 7'(MAX_COLS)) ? LW'(MAX_COLS)
                                                              : LW'(r_cfg_cols);
                        n_piv   = '0;
                        n_col   = '0;
                        n_state = S_COL;
                    end
                end
            end
            S_COL: begin
                // finish when columns or rows run out
                if (r_col == r_ncols || r_piv == r_nrows) begin
                    n_rank  = gfge_pkg::RANK_W'(r_piv);
                    n_row   = '0;
                    n_state = S_EM_RD;
                end else begin
                    n_row   = r_piv;
                    n_state = S_SR_RD;
                end
            end
            S_SR_RD: begin
                n_state = S_SR_EV;
            end
            S_SR_EV: begin
                // test the column bit of the row just read
                if (w_rd_bit) begin
                    n_prow  = w_rdata;
                    n_found = r_row[AW-1:0];
                    if (r_row == r_piv) begin
                        n_row   = '0;
                        n_state = S_EL_RD;
                    end else begin
                        n_state = S_SW_RD;
                    end
                end else if (w_row_last) begin
                    n_col   = r_col + LW'(1);
                    n_state = S_COL;
                end else begin
                    n_row   = r_row + CW'(1);
                    n_state = S_SR_RD;
                end
            end
            S_SW_RD: begin
                w_raddr = r_piv[AW-1:0];
                n_state = S_SW_EV;
            end
            S_SW_EV: begin
                // move the old pivot-place row down
                w_we    = 1'b1;
                w_waddr = r_found;
                w_wdata = w_rdata;
                n_state = S_SW_WR;
            end
            S_SW_WR: begin
                // put the found row up at the pivot place
                w_we    = 1'b1;
                w_waddr = r_piv[AW-1:0];
                w_wdata = r_prow;
                n_row   = '0;
                n_state = S_EL_RD;
            end
            S_EL_RD: begin
                if (r_row == r_nrows) begin
                    // column done: record pivot, advance
                    w_pwe   = 1'b1;
                    n_piv   = r_piv + CW'(1);
                    n_col   = r_col + LW'(1);
                    n_state = S_COL;
                end else if (r_row == r_piv) begin
                    n_row = r_row + CW'(1);
                end else begin
                    n_state = S_EL_EV;
                end
            end
            S_EL_EV: begin
                // clear the column bit from this row
                w_we    = w_rd_bit;
                w_wdata = w_rdata ^ r_prow;
                n_row   = r_row + CW'(1);
                n_state = S_EL_RD;
            end
            S_EM_RD: begin
                n_state = S_EM_WT;
            end
            S_EM_WT: begin
                // hold the read address until the output register frees
                if (w_out_free) begin
                    n_m_tvalid = 1'b1;
                    n_m_tdata  = {3'b000,
                                  r_rank,
                                  w_hp ? w_prdata : gfge_pkg::PIVCOL_W'(0),
                                  w_hp,
                                  gfge_pkg::ROWIDX_W'(r_row),
                                  w_rdata};
                    n_m_tlast  = w_row_last;
                    if (w_row_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_row   = r_row + CW'(1);
                        n_state = S_EM_RD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State, configuration and output registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_cfg_rows <= gfge_pkg::CFG_ROWS_RESET;
            r_cfg_cols <= gfge_pkg::CFG_COLS_RESET;
            r_nrows    <= CW'(MAX_ROWS);
            r_ncols    <= LW'(MAX_COLS);
            r_piv      <= '0;
            r_col      <= '0;
            r_rank     <= '0;
            r_m_tvalid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_nrows    <= n_nrows;
            r_ncols    <= n_ncols;
            r_piv      <= n_piv;
            r_col      <= n_col;
            r_rank     <= n_rank;
            r_m_tvalid <= n_m_tvalid;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    gfge_pkg::CFG_ROWS_IN_USE: r_cfg_rows <= i_cfg_wdata;
                    gfge_pkg::CFG_COLS_IN_USE: r_cfg_cols <= i_cfg_wdata;
                    default: begin
                    end
                endcase
            end
        end
        r_row     <= n_row;
        r_found   <= n_found;
        r_prow    <= n_prow;
        r_m_tdata <= n_m_tdata;
        r_m_tlast <= n_m_tlast;
    end

    assign o_m_tvalid = r_m_tvalid;
    assign o_m_tdata  = r_m_tdata;
    assign o_m_tlast  = r_m_tlast;

    // Pivot row count never passes the rows in use
    a_piv_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_piv <= r_nrows)
        else $error("pivot count beyond rows in use");

    // Column counter never passes the columns in use
    a_col_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_col <= r_ncols)
        else $error("column counter beyond columns in use");

    // Clearing a column needs a real pivot row
    a_elim_piv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EL_RD || r_state == S_EL_EV) |-> r_piv < r_nrows)
        else $error("elimination without a pivot row");

    // A search hit on a lower row leads to a swap
    a_swap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SR_EV && w_rd_bit && r_row != r_piv) |=> r_state == S_SW_RD)
        else $error("pivot row not swapped up");

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the GF(2) Gauss-Jordan elimination block.
// Drives load and eliminate items, predicts every reduced row and checks each one.
// Depends on gfge_pkg and gf2_gauss_jordan_eliminate_top.
module tb_top;

    localparam int NROWS        = gfge_pkg::DEF_MAX_ROWS;
    localparam int NCOLS        = gfge_pkg::DEF_MAX_COLS;
    localparam int SETTLE_CYCLES = 16;
    localparam int END_CYCLES   = 64;
    localparam int IDLE_PCT     = 22;

    // One reduced row as it leaves the block
    typedef struct packed {
        logic [gfge_pkg::COEFF_W-1:0]  coeffs;
        logic                          parity;
        logic [gfge_pkg::ROWIDX_W-1:0] row;
        logic                          has_pivot;
        logic [gfge_pkg::PIVCOL_W-1:0] pivot_col;
        logic [gfge_pkg::RANK_W-1:0]   rank;
        logic                          last;
    } t_row_result;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n;
    logic                           i_cfg_we;
    logic [gfge_pkg::CFG_IDX_W-1:0] i_cfg_idx;
    logic [gfge_pkg::CFG_W-1:0]     i_cfg_wdata;
    logic                           i_s_tvalid;
    logic                           o_s_tready;
    logic [gfge_pkg::S_TDATA_W-1:0] i_s_tdata;
    logic                           i_s_tuser;
    logic                           o_m_tvalid;
    logic                           i_m_tready = 1'b0;
    logic [gfge_pkg::M_TDATA_W-1:0] o_m_tdata;
    logic                           o_m_tlast;

    // Predicted matrix state and configuration
    logic [gfge_pkg::COEFF_W-1:0]  row_coeff  [NROWS];
    logic                          row_parity [NROWS];
    logic [gfge_pkg::PIVCOL_W-1:0] row_pivot  [NROWS];
    bit                            row_loaded [NROWS];
    int                            rank_found;
    int                            cfg_rows;
    int                            cfg_cols;

    t_row_result reduced_rows[$];
    int          mismatch_count = 0;
    int          items_sent = 0;
    bit          steady_flow = 1'b0;

    gf2_gauss_jordan_eliminate_top u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast)
    );

    always #1 i_clk = ~i_clk;

    // Stall the result side at random unless a steady stretch is running
    always @(posedge i_clk) begin
        i_m_tready <= steady_flow || ($urandom_range(99) >= IDLE_PCT);
    end

    function automatic int eff_rows();
        return (cfg_rows < 1) ? 1 : ((cfg_rows > NROWS) ? NROWS : cfg_rows);
    endfunction

    // Reduce the rows in use to echelon form and queue one result per row
    function automatic void reduce_matrix();
        int nrows;
        int ncols;
        int piv;
        int col;
        int r;
        int found;
        logic [gfge_pkg::COEFF_W-1:0] tmp_c;
        logic tmp_p;
        t_row_result res;
        nrows = eff_rows();
        ncols = (cfg_cols > NCOLS) ? NCOLS : cfg_cols;
        piv = 0;
        for (col = 0; col < ncols && piv < nrows; col++) begin
            found = nrows;
            for (r = piv; r < nrows; r++) begin
                if (found == nrows && row_coeff[r][col]) found = r;
            end
            if (found != nrows) begin
                // bring the pivot row up
                tmp_c = row_coeff[found];
                tmp_p = row_parity[found];
                row_coeff[found] = row_coeff[piv];
                row_parity[found] = row_parity[piv];
                row_coeff[piv] = tmp_c;
                row_parity[piv] = tmp_p;
                // clear the column everywhere else
                for (r = 0; r < nrows; r++) begin
                    if (r != piv && row_coeff[r][col]) begin
                        row_coeff[r] = row_coeff[r] ^ row_coeff[piv];
                        row_parity[r] = row_parity[r] ^ row_parity[piv];
                    end
                end
                row_pivot[piv] = col[gfge_pkg::PIVCOL_W-1:0];
                piv++;
            end
        end
        for (r = piv; r < NROWS; r++) row_pivot[r] = '0;
        rank_found = piv;
        for (r = 0; r < nrows; r++) begin
            res.coeffs    = row_coeff[r];
            res.parity    = row_parity[r];
            res.row       = r[gfge_pkg::ROWIDX_W-1:0];
            res.has_pivot = (r < rank_found);
            res.pivot_col = (r < rank_found) ? row_pivot[r] : '0;
            res.rank      = rank_found[gfge_pkg::RANK_W-1:0];
            res.last      = (r == nrows - 1);
            reduced_rows.insert(reduced_rows.size(), res);
        end
    endfunction

    // Row contents that give both full and deficient rank
    function automatic logic [gfge_pkg::COEFF_W-1:0] random_row();
        case ($urandom_range(9))
            0: return '0;
            1: return '1;
            2: return 64'd1 << $urandom_range(63);
            3: return {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
            4: return row_coeff[$urandom_range(NROWS - 1)]
                      ^ row_coeff[$urandom_range(NROWS - 1)];
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %h actual %h", $time, name, want, got);
            mismatch_count++;
        end
    endfunction

    // Send one item, with random idle cycles ahead of it unless a steady stretch is running, then predict its effect
    task automatic send_item(input logic act, input logic [gfge_pkg::ROWIDX_W-1:0] idx,
                             input logic [gfge_pkg::COEFF_W-1:0] coeffs, input logic par);
        while (!steady_flow && $urandom_range(99) < IDLE_PCT) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= act;
        i_s_tdata  <= {1'b0, par, coeffs, idx};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        items_sent++;
        if (act == gfge_pkg::ACT_LOAD) begin
            row_coeff[idx]  = coeffs;
            row_parity[idx] = par;
            row_loaded[idx] = 1'b1;
        end else begin
            reduce_matrix();
        end
    endtask

    task automatic send_load(input int idx);
        send_item(gfge_pkg::ACT_LOAD, idx[gfge_pkg::ROWIDX_W-1:0], random_row(),
                  1'($urandom_range(1)));
    endtask

    // Load any row in use that was never written, then eliminate
    task automatic send_eliminate();
        int r;
        for (r = 0; r < eff_rows(); r++) begin
            if (!row_loaded[r]) send_load(r);
        end
        send_item(gfge_pkg::ACT_ELIM, 6'($urandom), {$urandom, $urandom},
                  1'($urandom_range(1)));
    endtask

    // Hold the input until every expected row has arrived, then settle
    task automatic wait_idle(input int settle);
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (reduced_rows.size() != 0) @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    // Write both size registers while the block is idle
    task automatic set_dims(input int rows, input int cols);
        wait_idle(SETTLE_CYCLES);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= gfge_pkg::CFG_ROWS_IN_USE;
        i_cfg_wdata <= rows[gfge_pkg::CFG_W-1:0];
        @(posedge i_clk);
        i_cfg_idx   <= gfge_pkg::CFG_COLS_IN_USE;
        i_cfg_wdata <= cols[gfge_pkg::CFG_W-1:0];
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        @(posedge i_clk);
        cfg_rows = rows;
        cfg_cols = cols;
    endtask

    // Zero row, dependent row, repeated elimination and size extremes
    task automatic test_directed();
        set_dims(4, 8);
        send_item(gfge_pkg::ACT_LOAD, 6'd0, 64'd0, 1'b0);
        send_item(gfge_pkg::ACT_LOAD, 6'd1, 64'h6, 1'b1);
        send_item(gfge_pkg::ACT_LOAD, 6'd2, '1, 1'b0);
        send_item(gfge_pkg::ACT_LOAD, 6'd3, ~64'h6, 1'b1);
        send_eliminate();
        wait_idle(0);
        send_eliminate();
        send_item(gfge_pkg::ACT_LOAD, 6'd63, 64'hA5A5_5A5A_F00F_0FF0, 1'b1);
        // zero rows act as one, zero columns give rank zero
        set_dims(0, 0);
        send_eliminate();
        set_dims(1, 1);
        send_item(gfge_pkg::ACT_LOAD, 6'd0, 64'd1, 1'b1);
        send_eliminate();
        // column count above the maximum saturates, top column pivots
        set_dims(2, 127);
        send_item(gfge_pkg::ACT_LOAD, 6'd0, 64'h8000_0000_0000_0000, 1'b0);
        send_item(gfge_pkg::ACT_LOAD, 6'd1, 64'hC000_0000_0000_0000, 1'b1);
        send_eliminate();
    endtask

    // Mostly well-formed load/eliminate sequences on small random sizes
    task automatic test_random_mix();
        int rows;
        int cols;
        int ops;
        int k;
        int r;
        while (items_sent < 270) begin
            case ($urandom_range(9))
                0: rows = 0;
                1: rows = $urandom_range(9, 16);
                default: rows = $urandom_range(1, 8);
            endcase
            case ($urandom_range(9))
                0: cols = 0;
                1: cols = 64;
                2: cols = $urandom_range(65, 127);
                default: cols = $urandom_range(1, 12);
            endcase
            set_dims(rows, cols);
            for (r = 0; r < eff_rows(); r++) send_load(r);
            ops = $urandom_range(3, 12);
            for (k = 0; k < ops; k++) begin
                if ($urandom_range(9) < 7) begin
                    send_load(($urandom_range(9) < 8) ? $urandom_range(eff_rows() - 1)
                                                     : $urandom_range(NROWS - 1));
                end else begin
                    send_eliminate();
                    if ($urandom_range(9) == 0) wait_idle(0);
                end
            end
            send_eliminate();
        end
    endtask

    // No idling on either side, eliminations back to back
    task automatic test_steady_stream();
        int k;
        set_dims(6, 10);
        steady_flow = 1'b1;
        for (k = 0; k < 6; k++) send_load(k);
        for (k = 0; k < 6; k++) begin
            send_eliminate();
            send_eliminate();
            send_load($urandom_range(5));
        end
        wait_idle(0);
        steady_flow = 1'b0;
    endtask

    // Full-size matrix, then counts above the maximum
    task automatic test_full_matrix();
        int k;
        set_dims(64, 64);
        for (k = 0; k < NROWS; k++) send_load(k);
        send_eliminate();
        set_dims(127, 100);
        for (k = 0; k < 10; k++) send_load($urandom_range(NROWS - 1));
        send_eliminate();
    endtask

    // Compare each accepted row against the oldest prediction
    always @(posedge i_clk) begin : row_checker
        t_row_result want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (reduced_rows.size() == 0) begin
                $display("%0t: unexpected row, expected none actual %h", $time, o_m_tdata);
                mismatch_count++;
            end else begin
                want = reduced_rows.pop_front();
                check_field("out_coeffs", want.coeffs, o_m_tdata[63:0]);
                check_field("out_parity", want.parity, o_m_tdata[64]);
                check_field("out_row", want.row, o_m_tdata[70:65]);
                check_field("has_pivot", want.has_pivot, o_m_tdata[71]);
                check_field("pivot_column", want.pivot_col, o_m_tdata[77:72]);
                check_field("matrix_rank", want.rank, o_m_tdata[84:78]);
                check_field("last", want.last, o_m_tlast);
            end
        end
    end

    initial begin
        int r;
        i_rst_n     <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_idx   <= gfge_pkg::CFG_ROWS_IN_USE;
        i_cfg_wdata <= '0;
        i_s_tvalid  <= 1'b0;
        i_s_tdata   <= '0;
        i_s_tuser   <= gfge_pkg::ACT_LOAD;
        for (r = 0; r < NROWS; r++) begin
            row_coeff[r]  = '0;
            row_parity[r] = 1'b0;
            row_pivot[r]  = '0;
            row_loaded[r] = 1'b0;
        end
        rank_found = 0;
        cfg_rows = gfge_pkg::CFG_ROWS_RESET;
        cfg_cols = gfge_pkg::CFG_COLS_RESET;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random_mix();
        test_steady_stream();
        test_full_matrix();

        wait_idle(END_CYCLES);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Stop a hung run
    initial begin
        #50000000;
        $display("Mismatches found");
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/gfge_pkg.sv
hw/rtl/gfge_ram.sv
hw/rtl/gf2_gauss_jordan_eliminate_top.sv
tb/tb_top.sv
